// ===== design/rwl_pkg.sv =====
// Shared constants, codes and beat types for the reader/writer lock arbiter.
`default_nettype none

package rwl_pkg;

  // Waiter queue depth and reader limit
  localparam int WAIT_DEPTH  = 16;
  localparam int MAX_READERS = 255;
  localparam int READER_LIMIT = (MAX_READERS < 255) ? MAX_READERS : 255;

  localparam int WAIT_AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);

  localparam int ID_W      = 4;
  localparam int READERS_W = 8;

  localparam logic [READERS_W-1:0] READER_LIMIT_V = READERS_W'(READER_LIMIT);

  // Request codes
  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_UNLOCK = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_FREE     = 3'd4;

  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] requester;
  } rwl_in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic                 wake_valid;
    logic [ID_W-1:0]      wake_id;
    logic                 wake_is_write;
    logic [READERS_W-1:0] readers_held;
    logic                 writer_held;
  } rwl_out_t;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] push_id;
  } fifo_ctl_t;

  typedef struct packed {
    logic            empty;
    logic            full;
    logic [ID_W-1:0] head_id;
  } fifo_sts_t;

endpackage

`default_nettype wire

// ===== design/rwl_wait_fifo.sv =====
// Queue of waiting requester identifiers.
`default_nettype none

module rwl_wait_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rwl_pkg::fifo_ctl_t  ctl,
  output rwl_pkg::fifo_sts_t  sts
);
  import rwl_pkg::*;

  logic [ID_W-1:0]    ids_r [WAIT_DEPTH];
  logic [WAIT_AW-1:0] head_r, head_nxt;
  logic [WAIT_CW-1:0] count_r, count_nxt;
  logic [WAIT_AW:0]   tail_sum;
  logic [WAIT_AW-1:0] tail;

  // Tail is head plus count, wrapped once
  assign tail_sum = (WAIT_AW+1)'(head_r) + (WAIT_AW+1)'(count_r);
  assign tail = (tail_sum >= (WAIT_AW+1)'(WAIT_DEPTH)) ?
                WAIT_AW'(tail_sum - (WAIT_AW+1)'(WAIT_DEPTH)) : tail_sum[WAIT_AW-1:0];

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt = (head_r == WAIT_AW'(WAIT_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ids_r[tail] <= ctl.push_id;
    end
  end

  assign sts.empty   = (count_r == '0);
  assign sts.full    = (count_r == WAIT_CW'(WAIT_DEPTH));
  assign sts.head_id = ids_r[head_r];

endmodule

`default_nettype wire

// ===== design/rwl_core.sv =====
// Lock state and grant decision for one request beat.
`default_nettype none

module rwl_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 fire,
  input  rwl_pkg::rwl_in_t    req,
  input  rwl_pkg::fifo_sts_t  wsts,
  input  rwl_pkg::fifo_sts_t  rsts,
  output rwl_pkg::fifo_ctl_t  wctl,
  output rwl_pkg::fifo_ctl_t  rctl,
  output rwl_pkg::rwl_out_t   res
);
  import rwl_pkg::*;

  logic                 writer_r, writer_nxt;
  logic [READERS_W-1:0] readers_r, readers_nxt;
  logic [READERS_W-1:0] rel_readers;
  logic [2:0]           status;
  logic                 wpush, rpush, wpop, rpop;

  // Readers left once an unlock has released its hold
  assign rel_readers = writer_r ? readers_r : readers_r - 1'b1;

  always_comb begin
    writer_nxt  = writer_r;
    readers_nxt = readers_r;
    status      = ST_FREE;
    wpush       = 1'b0;
    rpush       = 1'b0;
    wpop        = 1'b0;
    rpop        = 1'b0;
    unique case (req.action)
      ACT_READ: begin
        if (!writer_r) begin
          if (readers_r < READER_LIMIT_V) begin
            readers_nxt = readers_r + 1'b1;
            status      = ST_GRANTED;
          end else begin
            status = ST_REJECTED;
          end
        end else if (!rsts.full) begin
          rpush  = 1'b1;
          status = ST_QUEUED;
        end else begin
          status = ST_REJECTED;
        end
      end
      ACT_WRITE: begin
        if (!writer_r && readers_r == '0) begin
          writer_nxt = 1'b1;
          status     = ST_GRANTED;
        end else if (!wsts.full) begin
          wpush  = 1'b1;
          status = ST_QUEUED;
        end else begin
          status = ST_REJECTED;
        end
      end
      ACT_UNLOCK: begin
        if (writer_r || readers_r != '0) begin
          status      = ST_RELEASED;
          writer_nxt  = 1'b0;
          readers_nxt = rel_readers;
          // Prefer the oldest writer once the lock is free
          if (rel_readers == '0 && !wsts.empty) begin
            wpop       = 1'b1;
            writer_nxt = 1'b1;
          end else if (!rsts.empty && rel_readers < READER_LIMIT_V) begin
            rpop        = 1'b1;
            readers_nxt = rel_readers + 1'b1;
          end
        end
      end
      default: status = ST_FREE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      writer_r  <= 1'b0;
      readers_r <= '0;
    end else if (fire) begin
      writer_r  <= writer_nxt;
      readers_r <= readers_nxt;
    end
  end

  assign wctl.push    = fire & wpush;
  assign wctl.pop     = fire & wpop;
  assign wctl.push_id = req.requester;
  assign rctl.push    = fire & rpush;
  assign rctl.pop     = fire & rpop;
  assign rctl.push_id = req.requester;

  assign res.status        = status;
  assign res.wake_valid    = wpop | rpop;
  assign res.wake_id       = wpop ? wsts.head_id : (rpop ? rsts.head_id : '0);
  assign res.wake_is_write = wpop;
  assign res.readers_held  = readers_nxt;
  assign res.writer_held   = writer_nxt;

endmodule

`default_nettype wire

// ===== design/reader_writer_lock_arbiter.sv =====
// Top level of the reader/writer lock arbiter with writer-preferred wakeup.
//
// Usage: each input beat (in_valid/in_stall/in_data) carries one request:
// lock for read, lock for write or unlock, with the requester's identifier.
// Every request yields exactly one result beat (out_valid/out_stall/out_data)
// giving the status, the waiter woken by an unlock if any, and the lock
// holdings after the request.
// Path: the request sits in the input register while the core decides, and the
// result register loads when the request fires; out_stall can hold the request
// in the input register in between.
// Throughput: one request per cycle while out_stall does not hold a result,
// set by the update of the lock state and queue heads as each request fires.
// Stall: while out_stall holds a result, the input register fills and
// in_stall rises until the result is taken; no beat is lost or repeated.
// Reset (rst_n low, synchronous): lock free, both waiter queues empty, no
// beat in flight. Queue entries hold no reset value and are read only after
// they were written.
`default_nettype none

module reader_writer_lock_arbiter (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  rwl_pkg::rwl_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output rwl_pkg::rwl_out_t  out_data
);
  import rwl_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  rwl_in_t   s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  rwl_out_t  out_data_r;
  logic      advance;
  logic      fire;
  fifo_ctl_t wctl, rctl;
  fifo_sts_t wsts, rsts;
  rwl_out_t  res;

  // Advance the request stage whenever the result register is free or drains
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold while stalled, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  rwl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (s1_data_r),
    .wsts  (wsts),
    .rsts  (rsts),
    .wctl  (wctl),
    .rctl  (rctl),
    .res   (res)
  );

  // Writer waiters
  rwl_wait_fifo u_write_wait (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (wctl),
    .sts   (wsts)
  );

  // Reader waiters
  rwl_wait_fifo u_read_wait (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .sts   (rsts)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_excl_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.writer_held && out_data.readers_held != '0))
    else $error("writer and readers held together");

  a_wake_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.wake_valid |-> out_data.status == ST_RELEASED)
    else $error("wakeup without a release");

  a_wake_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.wake_valid |->
      out_data.wake_id == '0 && !out_data.wake_is_write)
    else $error("wake fields set without a wakeup");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(wctl.pop && wsts.empty) && !(rctl.pop && rsts.empty))
    else $error("pop from an empty waiter queue");
`endif

endmodule

`default_nettype wire
